>>> sv/url_percent_decoder_defines.svh
// Assertion macros used by the checker file
`ifndef URL_PERCENT_DECODER_DEFINES_SVH
`define URL_PERCENT_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define UPD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("url decoder check failed");

// Next-cycle implication, disabled while reset is asserted
`define UPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("url decoder check failed");

`endif

>>> sv/upd_pkg.sv
`timescale 1ns / 1ps

package upd_pkg;

  // Escape decoder phase
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_PCT  = 2'd1,
    PH_ONE  = 2'd2,
    PH_UNI  = 2'd3
  } phase_e;

  // Most bytes one input can release
  localparam int unsigned MaxRes = 6;
  localparam int unsigned NumW   = 3;

  // Burst queue depth (power of two, pointers wrap)
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  // Character codes
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // UTF-8 ranges and marks
  localparam logic [15:0] UTF_LIM1   = 16'h0080;
  localparam logic [15:0] UTF_LIM2   = 16'h0800;
  localparam logic [15:0] SURR_LO    = 16'hD800;
  localparam logic [15:0] SURR_HI    = 16'hE000;
  localparam logic [7:0]  UTF_LEAD2  = 8'hC0;
  localparam logic [7:0]  UTF_LEAD3  = 8'hE0;
  localparam logic [7:0]  UTF_CONT   = 8'h80;
  localparam logic [7:0]  UTF_MASK6  = 8'h3F;
  localparam logic [7:0]  UTF_MASK5  = 8'h1F;
  localparam logic [7:0]  UTF_MASK4  = 8'h0F;

  // Bytes released by one input; num zero means an empty end marker
  typedef struct packed {
    logic [MaxRes-1:0][7:0] data;
    logic [NumW-1:0]        num;
    logic                   last;
  } burst_t;

endpackage

>>> sv/url_percent_decoder.sv
`timescale 1ns / 1ps
// A result is registered in the burst queue, then in the back end's burst register.
// Throughput: one input byte per cycle while the burst queue has room; the output
// side gives one byte per cycle while m_axis_tready is high.
// A four-entry burst queue absorbs the bursts from failed escapes.
// Reset (rst_ni low, asynchronous) clears escape state, queue and plus_as_space.

module url_percent_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,    // plus_as_space
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_char
  input  logic        s_axis_tlast,   // in_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [8] run_last, [15:9] zero
  output logic        m_axis_tuser,   // [0] byte_valid
  output logic        m_axis_tlast    // stream_end
);

  logic            push, q_ready, q_valid, q_pop;
  upd_pkg::burst_t push_burst, head_burst;
  logic [7:0]      out_byte;
  logic            run_last;

  // Accept and classify bytes
  upd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_i  (q_ready),
    .in_char_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .push_o      (push),
    .burst_o     (push_burst)
  );

  assign s_axis_tready = q_ready;

  // Decouple front and back
  upd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_burst),
    .ready_o     (q_ready),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (head_burst)
  );

  // Serialize bursts onto the master side
  upd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_data_i     (head_burst),
    .q_pop_o      (q_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (out_byte),
    .byte_valid_o (m_axis_tuser),
    .run_last_o   (run_last),
    .stream_end_o (m_axis_tlast)
  );

  assign m_axis_tdata = {7'd0, run_last, out_byte};

endmodule

>>> sv/upd_front.sv
`timescale 1ns / 1ps

module upd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [7:0]        in_char_i,
  input  logic              in_last_i,
  output logic              push_o,
  output upd_pkg::burst_t   burst_o
);

  upd_pkg::phase_e phase_q, phase_d, phase_pre;
  logic [2:0]      cnt_q, cnt_d, cnt_pre;
  logic [15:0]     code_q, code_d, code_pre;
  logic [3:0][7:0] held_q, held_d;
  logic            plus_as_space_q;

  logic            is_hex;
  logic [3:0]      hex_val;
  logic [15:0]     code_full;
  logic            flush_mid, plain_en, hex_byte_en, utf_en, flush_end;
  logic            accept;
  logic [upd_pkg::MaxRes-1:0][7:0] data;
  logic [upd_pkg::NumW-1:0]        nb;

  assign accept    = in_valid_i && in_ready_i;
  assign code_full = {code_q[11:0], hex_val};

  // Decode hex digit
  always_comb begin
    is_hex  = 1'b1;
    hex_val = 4'd0;
    if (in_char_i inside {[8'h30:8'h39]}) begin
      hex_val = 4'(in_char_i - 8'h30);
    end else if (in_char_i inside {[8'h41:8'h46]}) begin
      hex_val = 4'(in_char_i - 8'h37);
    end else if (in_char_i inside {[8'h61:8'h66]}) begin
      hex_val = 4'(in_char_i - 8'h57);
    end else begin
      is_hex = 1'b0;
    end
  end

  // Classify the byte against the open escape
  always_comb begin
    phase_pre   = phase_q;
    cnt_pre     = cnt_q;
    code_pre    = code_q;
    held_d      = held_q;
    flush_mid   = 1'b0;
    plain_en    = 1'b0;
    hex_byte_en = 1'b0;
    utf_en      = 1'b0;
    case (phase_q)
      upd_pkg::PH_IDLE: begin
        plain_en = 1'b1;
      end
      upd_pkg::PH_PCT: begin
        if (in_char_i == upd_pkg::CH_U) begin
          phase_pre = upd_pkg::PH_UNI;
          cnt_pre   = 3'd0;
          code_pre  = 16'd0;
        end else if (is_hex) begin
          held_d[0] = in_char_i;
          cnt_pre   = 3'd1;
          code_pre  = {12'd0, hex_val};
          phase_pre = upd_pkg::PH_ONE;
        end else begin
          flush_mid = 1'b1;
          plain_en  = 1'b1;
        end
      end
      upd_pkg::PH_ONE: begin
        if (is_hex) begin
          hex_byte_en = 1'b1;
          phase_pre   = upd_pkg::PH_IDLE;
          cnt_pre     = 3'd0;
          code_pre    = 16'd0;
        end else begin
          flush_mid = 1'b1;
          plain_en  = 1'b1;
        end
      end
      upd_pkg::PH_UNI: begin
        if (is_hex) begin
          held_d[cnt_q[1:0]] = in_char_i;
          code_pre           = code_full;
          cnt_pre            = cnt_q + 3'd1;
          if (cnt_q >= 3'd3) begin
            utf_en    = 1'b1;
            phase_pre = upd_pkg::PH_IDLE;
            cnt_pre   = 3'd0;
            code_pre  = 16'd0;
          end
        end else begin
          flush_mid = 1'b1;
          plain_en  = 1'b1;
        end
      end
      default: begin
        plain_en = 1'b1;
      end
    endcase
    // Drop a failed escape, then let the byte open a new one
    if (flush_mid) begin
      phase_pre = upd_pkg::PH_IDLE;
      cnt_pre   = 3'd0;
      code_pre  = 16'd0;
    end
    if (plain_en && in_char_i == upd_pkg::CH_PCT) begin
      phase_pre = upd_pkg::PH_PCT;
      cnt_pre   = 3'd0;
      code_pre  = 16'd0;
    end
    // End of text closes any open escape
    flush_end = in_last_i && (phase_pre != upd_pkg::PH_IDLE);
    if (in_last_i) begin
      phase_d = upd_pkg::PH_IDLE;
      cnt_d   = 3'd0;
      code_d  = 16'd0;
    end else begin
      phase_d = phase_pre;
      cnt_d   = cnt_pre;
      code_d  = code_pre;
    end
  end

  // Gather the released bytes in order
  always_comb begin
    data = '0;
    nb   = '0;
    if (flush_mid) begin
      data[nb] = upd_pkg::CH_PCT;
      nb       = nb + 3'd1;
      if (phase_q == upd_pkg::PH_UNI) begin
        data[nb] = upd_pkg::CH_U;
        nb       = nb + 3'd1;
      end
      for (int k = 0; k < 4; k++) begin
        if (3'(k) < cnt_q) begin
          data[nb] = held_q[k];
          nb       = nb + 3'd1;
        end
      end
    end
    if (hex_byte_en) begin
      data[nb] = {code_q[3:0], hex_val};
      nb       = nb + 3'd1;
    end
    if (utf_en) begin
      if (code_full < upd_pkg::UTF_LIM1) begin
        data[nb] = code_full[7:0];
        nb       = nb + 3'd1;
      end else if (code_full < upd_pkg::UTF_LIM2) begin
        data[nb] = upd_pkg::UTF_LEAD2 | (code_full[13:6] & upd_pkg::UTF_MASK5);
        nb       = nb + 3'd1;
        data[nb] = upd_pkg::UTF_CONT | (code_full[7:0] & upd_pkg::UTF_MASK6);
        nb       = nb + 3'd1;
      end else if (code_full >= upd_pkg::SURR_LO && code_full < upd_pkg::SURR_HI) begin
        // surrogate code: consumed, nothing sent
        nb = nb;
      end else begin
        data[nb] = upd_pkg::UTF_LEAD3 | ({4'd0, code_full[15:12]} & upd_pkg::UTF_MASK4);
        nb       = nb + 3'd1;
        data[nb] = upd_pkg::UTF_CONT | (code_full[13:6] & upd_pkg::UTF_MASK6);
        nb       = nb + 3'd1;
        data[nb] = upd_pkg::UTF_CONT | (code_full[7:0] & upd_pkg::UTF_MASK6);
        nb       = nb + 3'd1;
      end
    end
    if (plain_en && in_char_i != upd_pkg::CH_PCT) begin
      if (in_char_i == upd_pkg::CH_PLUS && plus_as_space_q) begin
        data[nb] = upd_pkg::CH_SPACE;
      end else begin
        data[nb] = in_char_i;
      end
      nb = nb + 3'd1;
    end
    if (flush_end) begin
      data[nb] = upd_pkg::CH_PCT;
      nb       = nb + 3'd1;
      if (phase_pre == upd_pkg::PH_UNI) begin
        data[nb] = upd_pkg::CH_U;
        nb       = nb + 3'd1;
      end
      for (int k = 0; k < 4; k++) begin
        if (3'(k) < cnt_pre) begin
          data[nb] = held_d[k];
          nb       = nb + 3'd1;
        end
      end
    end
  end

  // Hand a burst to the queue when it carries bytes or ends the text
  assign push_o        = accept && ((nb != '0) || in_last_i);
  assign burst_o.data  = data;
  assign burst_o.num   = nb;
  assign burst_o.last  = in_last_i;

  // Advance escape state on each accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= upd_pkg::PH_IDLE;
      cnt_q   <= 3'd0;
      code_q  <= 16'd0;
    end else if (accept) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      code_q  <= code_d;
    end
  end

  // Hold the escape digits
  always_ff @(posedge clk_i) begin
    if (accept) begin
      held_q <= held_d;
    end
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plus_as_space_q <= 1'b0;
    end else if (cfg_we_i) begin
      plus_as_space_q <= cfg_wdata_i;
    end
  end

endmodule

>>> sv/upd_queue.sv
`timescale 1ns / 1ps

module upd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  upd_pkg::burst_t push_data_i,
  output logic            ready_o,
  input  logic            pop_i,
  output logic            valid_o,
  output upd_pkg::burst_t pop_data_o
);

  upd_pkg::burst_t             mem_q [upd_pkg::QDepth];
  logic [upd_pkg::QPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [upd_pkg::QPtrW:0]     count_q;
  logic                        do_push, do_pop;

  assign ready_o    = (count_q != (upd_pkg::QPtrW+1)'(upd_pkg::QDepth));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && ready_o;
  assign do_pop     = pop_i && valid_o;

  // Store bursts
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + upd_pkg::QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + upd_pkg::QPtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + (upd_pkg::QPtrW+1)'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - (upd_pkg::QPtrW+1)'(1);
      end
    end
  end

endmodule

>>> sv/upd_back.sv
`timescale 1ns / 1ps

module upd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  upd_pkg::burst_t q_data_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            byte_valid_o,
  output logic            run_last_o,
  output logic            stream_end_o
);

  upd_pkg::burst_t          cur_q;
  logic                     cur_vld_q;
  logic [upd_pkg::NumW-1:0] pos_q;
  logic                     is_final, take, load;

  assign is_final = (cur_q.num == '0) || (pos_q == cur_q.num - 3'd1);
  assign take     = cur_vld_q && out_ready_i;
  assign load     = q_valid_i && (!cur_vld_q || (take && is_final));
  assign q_pop_o  = load;

  // Present the current byte of the burst
  assign out_valid_o  = cur_vld_q;
  assign byte_valid_o = (cur_q.num != '0);
  assign out_byte_o   = byte_valid_o ? cur_q.data[pos_q] : 8'd0;
  assign run_last_o   = is_final;
  assign stream_end_o = is_final && cur_q.last;

  // Step through the burst, reload from the queue at its end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q <= 1'b0;
      pos_q     <= '0;
    end else if (load) begin
      cur_vld_q <= 1'b1;
      pos_q     <= '0;
    end else if (take && is_final) begin
      cur_vld_q <= 1'b0;
    end else if (take) begin
      pos_q <= pos_q + 3'd1;
    end
  end

  // Hold the burst payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= q_data_i;
    end
  end

endmodule

>>> sv/upd_checker.sv
`timescale 1ns / 1ps
`include "url_percent_decoder_defines.svh"

module upd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_we_i,
  input logic        cfg_wdata_i,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // A stalled result holds its payload
  `UPD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

  // An empty marker is a zero byte with run_last set, closing the text
  `UPD_ASSERT_NOW(a_empty_marker, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == 16'h0100 && m_axis_tlast)

  // The end of the text also closes the run of its input
  `UPD_ASSERT_NOW(a_end_closes_run, clk_i, rst_ni, m_axis_tvalid && m_axis_tlast, m_axis_tdata[8])

  // Padding bits stay zero
  `UPD_ASSERT_NOW(a_pad_zero, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[15:9] == 7'd0)

endmodule

bind url_percent_decoder upd_checker u_upd_checker (.*);

>>> tb/sv/tb_url_percent_decoder.sv
`timescale 1ns / 1ps

module tb_url_percent_decoder;

  localparam logic [7:0] CH_ZERO = "0";
  localparam logic [7:0] CH_NINE = "9";
  localparam logic [7:0] CH_A_UP = "A";
  localparam logic [7:0] CH_F_UP = "F";
  localparam logic [7:0] CH_A_LO = "a";
  localparam logic [7:0] CH_F_LO = "f";

  localparam int unsigned MaxWait   = 12;
  localparam int          SrcSide   = 0;
  localparam int          SinkSide  = 1;
  localparam int unsigned DrainWait = 4;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } src_char_t;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       run_last;
    logic       stream_end;
  } dec_byte_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic        cfg_wdata_i   = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  url_percent_decoder i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // Decoder state mirrored for prediction
  upd_pkg::phase_e esc_phase = upd_pkg::PH_IDLE;
  logic [2:0]  esc_count = '0;
  logic [15:0] esc_code  = '0;
  logic [7:0]  esc_held [4];
  logic        plus_mode = 1'b0;
  logic [7:0]  burst [$];

  src_char_t   pending_chars [$];
  dec_byte_t   decoded_q [$];
  int unsigned errors = 0;
  int unsigned calm [2] = '{0, 0};

  function automatic logic hex_value(input logic [7:0] c, output logic [3:0] v);
    v = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      v = 4'(c - CH_ZERO);
      return 1'b1;
    end
    if (c >= CH_A_UP && c <= CH_F_UP) begin
      v = 4'(c - CH_A_UP + 8'd10);
      return 1'b1;
    end
    if (c >= CH_A_LO && c <= CH_F_LO) begin
      v = 4'(c - CH_A_LO + 8'd10);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Append one byte to the burst of the current input
  task automatic add_byte(input logic [7:0] b);
    burst.insert(burst.size(), b);
  endtask

  task automatic clear_escape();
    esc_phase = upd_pkg::PH_IDLE;
    esc_count = '0;
    esc_code  = '0;
  endtask

  // Send an open escape on as its original characters
  task automatic flush_escape();
    add_byte(upd_pkg::CH_PCT);
    if (esc_phase == upd_pkg::PH_UNI) add_byte(upd_pkg::CH_U);
    for (int k = 0; k < esc_count && k < 4; k++) add_byte(esc_held[k]);
    clear_escape();
  endtask

  task automatic plain_byte(input logic [7:0] c);
    if (c == upd_pkg::CH_PCT) begin
      clear_escape();
      esc_phase = upd_pkg::PH_PCT;
    end else if (c == upd_pkg::CH_PLUS && plus_mode) begin
      add_byte(upd_pkg::CH_SPACE);
    end else begin
      add_byte(c);
    end
  endtask

  task automatic emit_utf8(input logic [15:0] code);
    if (code < upd_pkg::UTF_LIM1) begin
      add_byte({1'b0, code[6:0]});
    end else if (code < upd_pkg::UTF_LIM2) begin
      add_byte(upd_pkg::UTF_LEAD2 | {3'b0, code[10:6]});
      add_byte(upd_pkg::UTF_CONT | {2'b0, code[5:0]});
    end else if (code >= upd_pkg::SURR_LO && code < upd_pkg::SURR_HI) begin
      // surrogate codes are consumed silently
    end else begin
      add_byte(upd_pkg::UTF_LEAD3 | {4'b0, code[15:12]});
      add_byte(upd_pkg::UTF_CONT | {2'b0, code[11:6]});
      add_byte(upd_pkg::UTF_CONT | {2'b0, code[5:0]});
    end
  endtask

  // Advance the mirrored decoder by one input byte and queue its output bytes
  task automatic decode_char(input logic [7:0] c, input logic last);
    logic [3:0] v;
    logic       is_hex;
    int         n;
    dec_byte_t  d;
    burst.delete();
    is_hex = hex_value(c, v);
    case (esc_phase)
      upd_pkg::PH_PCT: begin
        if (c == upd_pkg::CH_U) begin
          esc_phase = upd_pkg::PH_UNI;
          esc_count = '0;
          esc_code  = '0;
        end else if (is_hex) begin
          esc_held[0] = c;
          esc_count   = 3'd1;
          esc_code    = {12'b0, v};
          esc_phase   = upd_pkg::PH_ONE;
        end else begin
          flush_escape();
          plain_byte(c);
        end
      end
      upd_pkg::PH_ONE: begin
        if (is_hex) begin
          add_byte({esc_code[3:0], v});
          clear_escape();
        end else begin
          flush_escape();
          plain_byte(c);
        end
      end
      upd_pkg::PH_UNI: begin
        if (is_hex) begin
          esc_code = {esc_code[11:0], v};
          esc_held[esc_count[1:0]] = c;
          esc_count++;
          if (esc_count >= 3'd4) begin
            emit_utf8(esc_code);
            clear_escape();
          end
        end else begin
          flush_escape();
          plain_byte(c);
        end
      end
      default: plain_byte(c);
    endcase

    // Close out a cut-short escape at the end of the text
    if (last && esc_phase != upd_pkg::PH_IDLE) flush_escape();

    n = burst.size();
    if (last && n == 0) begin
      d = '{8'h00, 1'b0, 1'b1, 1'b1};
      decoded_q.insert(decoded_q.size(), d);
    end else begin
      for (int i = 0; i < n; i++) begin
        d = '{burst[i], 1'b1, i == n - 1, last && i == n - 1};
        decoded_q.insert(decoded_q.size(), d);
      end
    end
  endtask

  // Waits drawn per transaction, with occasional runs at full rate
  function automatic int unsigned draw_wait(input int side);
    if (calm[side] > 0) begin
      calm[side]--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm[side] = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, MaxWait);
  endfunction

  // Source driver
  int unsigned src_wait = 0;
  src_char_t   next_char;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) decode_char(s_axis_tdata, s_axis_tlast);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_wait > 0) begin
          src_wait--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_chars.size() != 0) begin
          next_char = pending_chars.pop_front();
          s_axis_tdata  <= next_char.ch;
          s_axis_tlast  <= next_char.last;
          s_axis_tvalid <= 1'b1;
          src_wait = draw_wait(SrcSide);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Sink monitor: check each result transaction against the oldest prediction
  int unsigned sink_wait = 0;
  dec_byte_t   want;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (decoded_q.size() == 0) begin
          $error("unexpected result: out_byte %h byte_valid %b", m_axis_tdata[7:0],
                 m_axis_tuser);
          errors++;
        end else begin
          want = decoded_q.pop_front();
          if (m_axis_tdata[7:0] !== want.data) begin
            $error("out_byte: expected %h, got %h", want.data, m_axis_tdata[7:0]);
            errors++;
          end
          if (m_axis_tuser !== want.valid) begin
            $error("byte_valid: expected %b, got %b", want.valid, m_axis_tuser);
            errors++;
          end
          if (m_axis_tdata[8] !== want.run_last) begin
            $error("run_last: expected %b, got %b", want.run_last, m_axis_tdata[8]);
            errors++;
          end
          if (m_axis_tlast !== want.stream_end) begin
            $error("stream_end: expected %b, got %b", want.stream_end, m_axis_tlast);
            errors++;
          end
        end
        sink_wait = draw_wait(SinkSide);
      end
      if (sink_wait > 0) begin
        sink_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Stimulus helpers
  task automatic put_char(input logic [7:0] c, input logic last);
    src_char_t sc;
    sc = '{c, last};
    pending_chars.insert(pending_chars.size(), sc);
  endtask

  task automatic put_text(input string s, input logic last_at_end);
    for (int i = 0; i < s.len(); i++) put_char(s[i], last_at_end && i == s.len() - 1);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return CH_ZERO + 8'(v);
    if ($urandom_range(0, 1) == 1) return CH_A_UP + 8'(v) - 8'd10;
    return CH_A_LO + 8'(v) - 8'd10;
  endfunction

  // Code points spread over the one-, two- and three-byte UTF-8 lengths and the surrogate band
  function automatic logic [15:0] pick_code();
    logic [15:0] bounds [10] = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800,
                                 16'hD7FF, 16'hD800, 16'hDFFF, 16'hE000, 16'hFFFF};
    case ($urandom_range(0, 5))
      0:       return 16'($urandom_range(0, upd_pkg::UTF_LIM1 - 1));
      1:       return 16'($urandom_range(upd_pkg::UTF_LIM1, upd_pkg::UTF_LIM2 - 1));
      2:       return 16'($urandom_range(upd_pkg::UTF_LIM2, upd_pkg::SURR_LO - 1));
      3:       return 16'($urandom_range(upd_pkg::SURR_LO, upd_pkg::SURR_HI - 1));
      4:       return 16'($urandom_range(upd_pkg::SURR_HI, 16'hFFFF));
      default: return bounds[$urandom_range(0, 9)];
    endcase
  endfunction

  // One random token: a plain byte, a well-formed escape or a broken one
  task automatic add_token();
    logic [7:0]  prefix [$];
    logic [15:0] code;
    int unsigned kind;
    int unsigned span;
    logic        fin;
    kind = $urandom_range(0, 99);
    fin  = ($urandom_range(0, 9) == 0);
    if (kind < 20) begin
      put_char(8'($urandom_range(0, 255)), fin);
    end else if (kind < 28) begin
      put_char(upd_pkg::CH_PLUS, fin);
    end else if (kind < 50) begin
      code = 16'($urandom_range(0, 255));
      put_char(upd_pkg::CH_PCT, 1'b0);
      put_char(hex_char(code[7:4]), 1'b0);
      put_char(hex_char(code[3:0]), fin);
    end else if (kind < 75) begin
      code = pick_code();
      put_char(upd_pkg::CH_PCT, 1'b0);
      put_char(upd_pkg::CH_U, 1'b0);
      put_char(hex_char(code[15:12]), 1'b0);
      put_char(hex_char(code[11:8]), 1'b0);
      put_char(hex_char(code[7:4]), 1'b0);
      put_char(hex_char(code[3:0]), fin);
    end else begin
      prefix.insert(prefix.size(), upd_pkg::CH_PCT);
      if ($urandom_range(0, 1) == 1) begin
        prefix.insert(prefix.size(), upd_pkg::CH_U);
        span = $urandom_range(0, 3);
      end else begin
        span = $urandom_range(0, 1);
      end
      for (int k = 0; k < span; k++) begin
        prefix.insert(prefix.size(), hex_char(4'($urandom_range(0, 15))));
      end
      if ($urandom_range(0, 3) == 0) begin
        // cut short by the end of the text
        for (int k = 0; k < prefix.size(); k++) put_char(prefix[k], k == prefix.size() - 1);
      end else begin
        // cut by a stray byte, often one that opens a new escape
        for (int k = 0; k < prefix.size(); k++) put_char(prefix[k], 1'b0);
        if ($urandom_range(0, 2) == 0) put_char(upd_pkg::CH_PCT, fin);
        else put_char(8'($urandom_range(0, 255)), fin);
      end
    end
  endtask

  task automatic fill_random(input int unsigned count);
    int unsigned start;
    start = pending_chars.size();
    while (pending_chars.size() - start < count) add_token();
    // close the text so the decoder is idle afterward
    if (!pending_chars[pending_chars.size() - 1].last)
      put_char(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Wait until every byte is sent and every prediction is matched
  task automatic drain();
    while (pending_chars.size() != 0 || s_axis_tvalid || decoded_q.size() != 0)
      @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic set_plus(input logic v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    plus_mode = v;
  endtask

  // Reset, directed cases, then random phases under alternating plus mapping
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_plus(1'b0);
    put_char(8'h00, 1'b0);
    put_char(8'hFF, 1'b0);
    put_char(upd_pkg::CH_PLUS, 1'b0);
    put_text("%4a", 1'b0);
    put_text("%uDC00", 1'b1);
    put_text("%u07FF", 1'b0);
    put_text("%G", 1'b0);
    put_text("%uABC%", 1'b1);
    drain();

    set_plus(1'b1);
    put_text("+%2B", 1'b1);
    drain();

    for (int p = 0; p < 4; p++) begin
      set_plus(p % 2 == 1);
      fill_random(88);
      drain();
    end

    if (errors == 0) begin
      $display("tb_url_percent_decoder: clean");
    end else begin
      $display("tb_url_percent_decoder: errors");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #5_000_000;
    $display("tb_url_percent_decoder: errors");
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/upd_pkg.sv
sv/upd_front.sv
sv/upd_queue.sv
sv/upd_back.sv
sv/url_percent_decoder.sv
sv/upd_checker.sv
tb/sv/tb_url_percent_decoder.sv
